// ----- src/heading_pid_step_unit_macros.svh -----
`ifndef HEADING_PID_STEP_UNIT_MACROS_SVH
`define HEADING_PID_STEP_UNIT_MACROS_SVH

// Concurrent check on the clock, quiet while reset is high.
`define HPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in one cycle implies a result in the next.
`define HPS_ASSERT_NEXT(label, cond, result, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (result)) \
      else $error(msg);

`endif

// ----- src/hps_pkg.sv -----
`default_nettype none

package hps_pkg;

   localparam int SAMPLE_BITS       = 12;
   localparam int INTEGRAL_BITS_DEF = 32;

   localparam int YAW_BITS      = 9;
   localparam int SETPOINT_BITS = 9;
   localparam int PERIOD_BITS   = 16;
   localparam int ZONE_BITS     = 9;
   localparam int DRIVE_BITS    = 14;
   localparam int STATUS_BITS   = 2;

   // heading error, error difference, 4800 * period, 800 * derivative sample
   localparam int ERR_BITS     = 10;
   localparam int DIFF_BITS    = 11;
   localparam int DIVISOR_BITS = 29;
   localparam int GAIN_D_BITS  = SAMPLE_BITS + 10;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;

   localparam logic [ERR_BITS-1:0] HEADING_OFFSET = 10'd180;
   localparam logic [ERR_BITS-1:0] FULL_TURN      = 10'd360;
   localparam int                  DRIVE_CENTER   = 750;

   localparam logic [2:0] REG_SETPOINT  = 3'd0;
   localparam logic [2:0] REG_PERIOD    = 3'd1;
   localparam logic [2:0] REG_ZONE      = 3'd2;
   localparam logic [2:0] REG_DRIVE_MIN = 3'd3;
   localparam logic [2:0] REG_DRIVE_MAX = 3'd4;

   localparam logic [STATUS_BITS-1:0] STAT_OK  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_MIN = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_MAX = 2'd2;

   typedef struct packed {
      logic [YAW_BITS-1:0]    raw_yaw;
      logic [SAMPLE_BITS-1:0] gain_p_sample;
      logic [SAMPLE_BITS-1:0] gain_i_sample;
      logic [SAMPLE_BITS-1:0] gain_d_sample;
   } req_type;

   typedef struct packed {
      logic [DRIVE_BITS-1:0]  drive;
      logic [STATUS_BITS-1:0] clamp_status;
   } rsp_type;

   typedef struct packed {
      logic [SETPOINT_BITS-1:0] setpoint;
      logic [PERIOD_BITS-1:0]   sample_period;
      logic [ZONE_BITS-1:0]     integral_zone;
      logic [DRIVE_BITS-1:0]    drive_min;
      logic [DRIVE_BITS-1:0]    drive_max;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      setpoint:      9'd180,
      sample_period: 16'd50,
      integral_zone: 9'd3,
      drive_min:     14'd138,
      drive_max:     14'd1111
   };

   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

endpackage

`default_nettype wire

// ----- src/hps_csr.sv -----
`default_nettype none

module hps_csr
   import hps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SETPOINT:  cfg_in.setpoint      = pwdata[SETPOINT_BITS-1:0];
            REG_PERIOD:    cfg_in.sample_period = pwdata[PERIOD_BITS-1:0];
            REG_ZONE:      cfg_in.integral_zone = pwdata[ZONE_BITS-1:0];
            REG_DRIVE_MIN: cfg_in.drive_min     = pwdata[DRIVE_BITS-1:0];
            REG_DRIVE_MAX: cfg_in.drive_max     = pwdata[DRIVE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SETPOINT:  prdata = CSR_DATA_BITS'(cfg_ff.setpoint);
         REG_PERIOD:    prdata = CSR_DATA_BITS'(cfg_ff.sample_period);
         REG_ZONE:      prdata = CSR_DATA_BITS'(cfg_ff.integral_zone);
         REG_DRIVE_MIN: prdata = CSR_DATA_BITS'(cfg_ff.drive_min);
         REG_DRIVE_MAX: prdata = CSR_DATA_BITS'(cfg_ff.drive_max);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/hps_addsub.sv -----
`default_nettype none

module hps_addsub #(
   parameter int WIDTH = 52
)(
   input  logic [WIDTH-1:0] lhs,
   input  logic [WIDTH-1:0] rhs,
   input  logic             sub,
   output logic [WIDTH-1:0] sum,
   output logic             neg
);

   assign sum = sub ? (lhs - rhs) : (lhs + rhs);
   assign neg = sum[WIDTH-1];

endmodule

`default_nettype wire

// ----- src/hps_core.sv -----
`default_nettype none

module hps_core
   import hps_pkg::*;
#(
   parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  req_type       req,
   input  cfg_type       cfg,
   input  logic          res_take,
   output core_stat_type stat,
   output rsp_type       res
);

   localparam int IB     = INTEGRAL_BITS;
   localparam int M_BITS = (IB > SAMPLE_BITS + 22) ? IB : SAMPLE_BITS + 22;
   localparam int WN     = M_BITS + 18;   // full numerator plus headroom for the divide
   localparam int QB     = M_BITS - 12;   // quotient magnitude bits
   localparam int DW     = QB + 2;
   localparam int MW     = PERIOD_BITS;
   localparam int MAXLEN = (QB > MW) ? QB : MW;
   localparam int CW     = $clog2(MAXLEN);

   localparam logic signed [WN-1:0] INT_HI = {{(WN-IB+1){1'b0}}, {(IB-1){1'b1}}};
   localparam logic signed [WN-1:0] INT_LO = {{(WN-IB+1){1'b1}}, {(IB-1){1'b0}}};

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_ISET, S_MUL_I, S_SAT, S_MUL_P, S_MOVE, S_MUL_A,
      S_BSET, S_MUL_B, S_DIVSET, S_DIV, S_FIX, S_CLAMP, S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   req_type                   item_ff, item_in;
   logic signed [ERR_BITS-1:0]  err_ff, err_in;
   logic signed [ERR_BITS-1:0]  last_err_ff, last_err_in;
   logic signed [DIFF_BITS-1:0] diff_ff, diff_in;
   logic                      inzone_ff, inzone_in;
   logic [DIVISOR_BITS-1:0]   divisor_ff, divisor_in;
   logic signed [IB-1:0]      integ_ff, integ_in;
   logic signed [WN-1:0]      acc_ff, acc_in;
   logic [WN-1:0]             mcand_ff, mcand_in;
   logic [MW-1:0]             mplier_ff, mplier_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [QB-1:0]             quot_ff, quot_in;
   logic                      neg_ff, neg_in;
   logic signed [DW-1:0]      drv_ff, drv_in;
   rsp_type                   res_ff, res_in;

   logic [ERR_BITS-1:0]         yaw_sum, heading, err_abs;
   logic signed [ERR_BITS-1:0]  err_now;
   logic signed [DIFF_BITS-1:0] diff_now;
   logic                        inzone_now;
   logic [PERIOD_BITS-1:0]      period_eff;
   logic [DIVISOR_BITS-1:0]     pe_w, divisor_now;
   logic [GAIN_D_BITS-1:0]      gd_w, gain_d_800;
   logic signed [IB-1:0]        integ_sat;
   logic [CW-1:0]               len_last;
   logic                        mul_signed, cnt_last;
   logic                        alu_sub, alu_neg;
   logic [WN-1:0]               alu_sum;
   logic signed [QB:0]          quot_signed;
   logic signed [DW-1:0]        min_w, max_w, clamp_lo;
   logic                        lo_hit, hi_hit;

   // heading = (yaw + 180) mod 360; the sum stays below twice a turn
   assign yaw_sum    = ERR_BITS'(item_ff.raw_yaw) + HEADING_OFFSET;
   assign heading    = (yaw_sum >= FULL_TURN) ? (yaw_sum - FULL_TURN) : yaw_sum;
   assign err_now    = ERR_BITS'(cfg.setpoint) - heading;
   assign err_abs    = err_now[ERR_BITS-1] ? ERR_BITS'(-err_now) : err_now;
   assign inzone_now = err_abs < ERR_BITS'(cfg.integral_zone);
   assign diff_now   = DIFF_BITS'(err_now) - DIFF_BITS'(last_err_ff);

   // 4800 = 4096 + 512 + 128 + 64
   assign period_eff  = (cfg.sample_period == '0) ? PERIOD_BITS'(1) : cfg.sample_period;
   assign pe_w        = DIVISOR_BITS'(period_eff);
   assign divisor_now = (pe_w << 12) + (pe_w << 9) + (pe_w << 7) + (pe_w << 6);

   // 800 = 512 + 256 + 32
   assign gd_w       = GAIN_D_BITS'(item_ff.gain_d_sample);
   assign gain_d_800 = (gd_w << 9) + (gd_w << 8) + (gd_w << 5);

   assign integ_sat = (acc_ff > INT_HI) ? INT_HI[IB-1:0] :
                      (acc_ff < INT_LO) ? INT_LO[IB-1:0] : acc_ff[IB-1:0];

   always_comb begin
      case (state_ff) inside
         S_MUL_I, S_MUL_P: begin
            len_last   = CW'(ERR_BITS - 1);
            mul_signed = 1'b1;
         end
         S_MUL_A: begin
            len_last   = CW'(PERIOD_BITS - 1);
            mul_signed = 1'b0;
         end
         S_MUL_B: begin
            len_last   = CW'(DIFF_BITS - 1);
            mul_signed = 1'b1;
         end
         default: begin
            len_last   = CW'(QB - 1);
            mul_signed = 1'b0;
         end
      endcase
   end

   assign cnt_last = (cnt_ff == len_last);
   // sign bit of a two's complement multiplier carries negative weight
   assign alu_sub  = (state_ff == S_DIV) || (cnt_last && mul_signed);

   hps_addsub #(
      .WIDTH (WN)
   ) u_addsub (
      .lhs (acc_ff),
      .rhs (mcand_ff),
      .sub (alu_sub),
      .sum (alu_sum),
      .neg (alu_neg)
   );

   // floor for a negative numerator: -1 - (~N div D)
   assign quot_signed = neg_ff ? ~{1'b0, quot_ff} : {1'b0, quot_ff};

   assign min_w    = DW'(cfg.drive_min);
   assign max_w    = DW'(cfg.drive_max);
   assign lo_hit   = drv_ff < min_w;
   assign clamp_lo = lo_hit ? min_w : drv_ff;
   assign hi_hit   = clamp_lo > max_w;

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      err_in      = err_ff;
      last_err_in = last_err_ff;
      diff_in     = diff_ff;
      inzone_in   = inzone_ff;
      divisor_in  = divisor_ff;
      integ_in    = integ_ff;
      acc_in      = acc_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      cnt_in      = cnt_ff;
      quot_in     = quot_ff;
      neg_in      = neg_ff;
      drv_in      = drv_ff;
      res_in      = res_ff;

      unique case (state_ff) inside
         S_IDLE: begin
            if (start) begin
               item_in  = req;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            err_in      = err_now;
            diff_in     = diff_now;
            last_err_in = err_now;
            inzone_in   = inzone_now;
            divisor_in  = divisor_now;
            state_in    = S_ISET;
         end
         S_ISET: begin
            // outside the zone the integral restarts from zero
            acc_in    = inzone_ff ? WN'(integ_ff) : '0;
            mcand_in  = inzone_ff ? WN'(item_ff.gain_i_sample) : '0;
            mplier_in = MW'(err_ff);
            cnt_in    = '0;
            state_in  = S_MUL_I;
         end
         S_MUL_I, S_MUL_P, S_MUL_A, S_MUL_B: begin
            if (mplier_ff[0]) begin
               acc_in = alu_sum;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_last) begin
               cnt_in = '0;
               case (state_ff)
                  S_MUL_I: state_in = S_SAT;
                  S_MUL_P: state_in = S_MOVE;
                  S_MUL_A: state_in = S_BSET;
                  default: state_in = S_DIVSET;
               endcase
            end
         end
         S_SAT: begin
            integ_in  = integ_sat;
            acc_in    = WN'(integ_sat);
            mcand_in  = WN'(item_ff.gain_p_sample) << 2;
            mplier_in = MW'(err_ff);
            state_in  = S_MUL_P;
         end
         S_MOVE: begin
            mcand_in  = acc_ff;
            acc_in    = '0;
            mplier_in = period_eff;
            state_in  = S_MUL_A;
         end
         S_BSET: begin
            mcand_in  = WN'(gain_d_800);
            mplier_in = MW'(diff_ff);
            state_in  = S_MUL_B;
         end
         S_DIVSET: begin
            neg_in   = acc_ff[WN-1];
            acc_in   = acc_ff[WN-1] ? ~acc_ff : acc_ff;
            mcand_in = WN'(divisor_ff) << (QB - 1);
            quot_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!alu_neg) begin
               acc_in = alu_sum;
            end
            quot_in  = {quot_ff[QB-2:0], !alu_neg};
            mcand_in = mcand_ff >> 1;
            cnt_in   = cnt_ff + CW'(1);
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            drv_in   = DW'(quot_signed) + DW'(DRIVE_CENTER);
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            // minimum first, maximum last
            res_in.drive        = hi_hit ? cfg.drive_max : clamp_lo[DRIVE_BITS-1:0];
            res_in.clamp_status = hi_hit ? STAT_MAX : (lo_hit ? STAT_MIN : STAT_OK);
            state_in            = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         last_err_ff <= '0;
         integ_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         last_err_ff <= last_err_in;
         integ_ff    <= integ_in;
      end
      item_ff    <= item_in;
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      inzone_ff  <= inzone_in;
      divisor_ff <= divisor_in;
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      cnt_ff     <= cnt_in;
      quot_ff    <= quot_in;
      neg_ff     <= neg_in;
      drv_ff     <= drv_in;
      res_ff     <= res_in;
   end

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule

`default_nettype wire

// ----- src/heading_pid_step_unit.sv -----
// Heading PID step. Each beat on the req_ channel carries a raw yaw in whole degrees and three
// gain potentiometer samples (P = sample/200, I = sample/800, D = sample); the block turns the
// yaw by 180 degrees, forms the error against the setpoint, runs the zoned and saturating
// integral, the derivative over the sample period, and returns one rsp_ beat with the drive
// value 750 + floor(total/6) clamped to [drive_min, drive_max] plus a clamp status. The
// registers sit at byte offsets 0x00 setpoint, 0x04 sample_period, 0x08 integral_zone,
// 0x0C drive_min, 0x10 drive_max; write them only while no item is in flight. One item is
// handled at a time, and a new one is accepted only once the core is idle again. The work
// is done in bit-serial passes through the one shared adder/subtractor: four multiplies of
// 10, 10, 16 and 11 steps and a restoring divide of one step per quotient bit, with
// QB = max(INTEGRAL_BITS, SAMPLE_BITS + 22) - 12 quotient bits. A finished result waits in
// the output register while the next item is taken.
`default_nettype none
`include "heading_pid_step_unit_macros.svh"

module heading_pid_step_unit
   import hps_pkg::*;
#(
   parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_item,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type       cfg;
   core_stat_type core_stat;
   rsp_type       core_res;
   logic          start, slot_free, res_take;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_item_ff, rsp_item_in;

   assign pready    = 1'b1;
   // hold off the sender while in reset as well
   assign req_stall = reset || !core_stat.idle;
   assign start     = req_valid && !req_stall;

   hps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   hps_core #(
      .INTEGRAL_BITS (INTEGRAL_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_item),
      .cfg      (cfg),
      .res_take (res_take),
      .stat     (core_stat),
      .res      (core_res)
   );

   // the output slot frees up in the same cycle its beat leaves
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign res_take  = core_stat.done && slot_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = core_res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `HPS_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, req_stall, "accepted beat did not occupy the core")
   `HPS_ASSERT(a_rsp_from_core, $rose(rsp_valid) |-> $past(core_stat.done), "result beat without a finished item")
   `HPS_ASSERT(a_drive_limits, (rsp_valid && (cfg.drive_min <= cfg.drive_max)) |-> ((rsp_item.drive >= cfg.drive_min) && (rsp_item.drive <= cfg.drive_max)), "drive outside limits")
   `HPS_ASSERT(a_min_status, (rsp_valid && (rsp_item.clamp_status == STAT_MIN)) |-> (rsp_item.drive == cfg.drive_min), "min clamp status with other drive")

endmodule

`default_nettype wire
